/* sv/ws2812_pkg.sv */
// ----------------------------------------------------------------------------
// ws2812_pkg: shared types and constants of the LED strip driver
// Command codes, register indexes, phase and control state types, and the
// packed command and result items.
// ----------------------------------------------------------------------------
package ws2812_pkg;

    // Pixel store geometry.
    localparam int MAX_PIXELS      = 256;
    localparam int BYTES_PER_PIXEL = 3;
    localparam int BYTE_W          = 8;
    localparam int ROW_W           = BYTE_W * BYTES_PER_PIXEL;
    localparam int ADDR_W          = $clog2(MAX_PIXELS);
    localparam int CNT_W           = $clog2(MAX_PIXELS + 1);

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_COUNT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HIGH_TICKS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_LOW_TICKS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_HIGH_TICKS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_LOW_TICKS   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LATCH_TICKS     = 3'd5;

    // Command codes.
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_SET   = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;
    localparam logic [1:0] CMD_SHOW  = 2'd3;

    // Color byte within a pixel row, sent in this order.
    localparam logic [1:0] COLOR_RED   = 2'd0;
    localparam logic [1:0] COLOR_GREEN = 2'd1;
    localparam logic [1:0] COLOR_BLUE  = 2'd2;

    // Line waveform phase.
    typedef enum logic [1:0] {
        PH_BIT_HIGH,
        PH_BIT_LOW,
        PH_LATCH_FIRST,
        PH_LATCH_SECOND
    } phase_t;

    // Command sequencer state.
    typedef enum logic {
        ST_ACCEPT,
        ST_EXEC
    } ctl_state_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] pixel_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } cmd_item_t;

    typedef struct packed {
        logic line_level;
        logic busy_res;
        logic show_accepted;
        logic frame_done;
    } res_item_t;

endpackage

/* sv/ws2812_strip_driver_unit.sv */
// ----------------------------------------------------------------------------
// ws2812_strip_driver_unit: WS2812 LED strip driver
// Pixel memory of one 24-bit row per pixel, command sequencer and waveform
// generator that moves the data line on by one tick per tick command.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake              Payload
//  -------   ---------  ---------------------  ----------------------------
//  command   in         cmd_valid / cmd_stall  cmd_item (cmd, index, R G B)
//  result    out        res_valid / res_stall  res_item (level, busy, ...)
//  config    in         cfg_wr_en              cfg_index, cfg_data
//
//  Every command has a transfer cycle, which issues the pixel memory read,
//  and an execute cycle, which uses its registered data and writes back.
//  Reset is asynchronous; per-row valid bits make the whole store read as
//  zero at once after reset or a clear, so no clearing pass is needed.
//  A stalled result holds the execute step, and the next command transfer
//  is taken while a finished result still waits in the output register.
//
module ws2812_strip_driver_unit
    import ws2812_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  cmd_valid,
    output logic                  cmd_stall,
    input  cmd_item_t             cmd_item,
    output logic                  res_valid,
    input  logic                  res_stall,
    output res_item_t             res_item
);

    // Configuration registers.
    logic [8:0]  pixel_count_reg;
    logic [14:0] zero_high_reg;
    logic [14:0] zero_low_reg;
    logic [14:0] one_high_reg;
    logic [14:0] one_low_reg;
    logic [15:0] latch_reg;

    // Sequencer and item registers.
    ctl_state_t  state_reg, state_next;
    cmd_item_t   item_reg;
    logic        exec_fire;

    // Pixel memory and its row valid bits.
    logic [ROW_W-1:0] pixel_mem [MAX_PIXELS];
    logic             row_valid_reg [MAX_PIXELS];
    logic [ROW_W-1:0] rd_row_reg;
    logic             rd_valid_reg;
    logic             set_ok;

    // Waveform state.
    logic             sending_reg, sending_next;
    logic [CNT_W-1:0] pix_reg, pix_next;
    logic [1:0]       color_reg, color_next;
    logic [2:0]       bit_reg, bit_next;
    logic [7:0]       cur_byte_reg, cur_byte_next;
    phase_t           phase_reg, phase_next;
    logic [15:0]      left_reg, left_next;

    // Result register.
    logic             res_valid_reg;
    res_item_t        res_item_reg;
    res_item_t        res_next;

    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_count_reg <= 9'd0;
            zero_high_reg   <= 15'd4;
            zero_low_reg    <= 15'd8;
            one_high_reg    <= 15'd8;
            one_low_reg     <= 15'd4;
            latch_reg       <= 16'd1000;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_PIXEL_COUNT:     pixel_count_reg <= cfg_data[8:0];
                CFG_ZERO_HIGH_TICKS: zero_high_reg   <= cfg_data[14:0];
                CFG_ZERO_LOW_TICKS:  zero_low_reg    <= cfg_data[14:0];
                CFG_ONE_HIGH_TICKS:  one_high_reg    <= cfg_data[14:0];
                CFG_ONE_LOW_TICKS:   one_low_reg     <= cfg_data[14:0];
                CFG_LATCH_TICKS:     latch_reg       <= cfg_data;
                default:             ;
            endcase
        end
    end

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_ACCEPT:
            begin
                if (cmd_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    state_next = ST_ACCEPT;
                end
            end
            default: state_next = ST_ACCEPT;
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        cmd_stall = 1'b1;
        exec_fire = 1'b0;
        unique case (state_reg)
            ST_ACCEPT: cmd_stall = 1'b0;
            ST_EXEC:   exec_fire = !res_valid_reg || !res_stall;
            default:   cmd_stall = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_ACCEPT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Command capture and pixel row read at the transfer.
    always_ff @(posedge clk)
    begin
        if (cmd_valid && !cmd_stall)
        begin
            item_reg     <= cmd_item;
            rd_row_reg   <= pixel_mem[pix_reg[ADDR_W-1:0]];
            rd_valid_reg <= row_valid_reg[pix_reg[ADDR_W-1:0]];
        end
    end

    // A set pixel lands only below both the pixel count and the store depth.
    assign set_ok = (16'(item_reg.pixel_index) < 16'(pixel_count_reg))
                 && (16'(item_reg.pixel_index) < 16'(MAX_PIXELS));

    // Pixel memory write in the execute cycle.
    always_ff @(posedge clk)
    begin
        if (exec_fire && item_reg.cmd == CMD_SET && set_ok)
        begin
            pixel_mem[item_reg.pixel_index[ADDR_W-1:0]] <=
                {item_reg.red, item_reg.green, item_reg.blue};
        end
    end

    // Row valid bits: a clear drops all of them, a set pixel marks its row.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_PIXELS; i++)
            begin
                row_valid_reg[i] <= 1'b0;
            end
        end
        else if (exec_fire)
        begin
            if (item_reg.cmd == CMD_CLEAR)
            begin
                for (int i = 0; i < MAX_PIXELS; i++)
                begin
                    row_valid_reg[i] <= 1'b0;
                end
            end
            else if (item_reg.cmd == CMD_SET && set_ok)
            begin
                row_valid_reg[item_reg.pixel_index[ADDR_W-1:0]] <= 1'b1;
            end
        end
    end

    // Waveform step and result of the command in the execute cycle.
    always_comb
    begin
        logic [15:0] count_sat;
        logic [15:0] load_len;
        logic [7:0]  fetched;
        logic        bit_val;
        phase_t      ph;
        logic [7:0]  cur;
        logic [15:0] left;

        sending_next  = sending_reg;
        pix_next      = pix_reg;
        color_next    = color_reg;
        bit_next      = bit_reg;
        cur_byte_next = cur_byte_reg;
        phase_next    = phase_reg;
        left_next     = left_reg;
        res_next      = '0;

        count_sat = (16'(pixel_count_reg) > 16'(MAX_PIXELS)) ?
                    16'(MAX_PIXELS) : 16'(pixel_count_reg);

        // Byte of the fetched row; a row not written since clear reads zero.
        unique case (color_reg)
            COLOR_RED:   fetched = rd_row_reg[ROW_W-1 -: BYTE_W];
            COLOR_GREEN: fetched = rd_row_reg[ROW_W-BYTE_W-1 -: BYTE_W];
            COLOR_BLUE:  fetched = rd_row_reg[BYTE_W-1:0];
            default:     fetched = 8'd0;
        endcase
        if (!rd_valid_reg)
        begin
            fetched = 8'd0;
        end

        ph       = phase_reg;
        cur      = cur_byte_reg;
        left     = left_reg;
        bit_val  = 1'b0;
        load_len = 16'd0;

        unique case (item_reg.cmd)
            CMD_TICK:
            begin
                if (sending_reg)
                begin
                    // Start of a phase: fetch the byte or enter the latch time.
                    if (left == 16'd0)
                    begin
                        if (ph == PH_BIT_HIGH && bit_reg == 3'd0)
                        begin
                            if (16'(pix_reg) >= count_sat)
                            begin
                                ph = PH_LATCH_FIRST;
                            end
                            else
                            begin
                                cur = fetched;
                            end
                        end
                        bit_val = cur[3'd7 - bit_reg];
                        unique case (ph)
                            PH_BIT_HIGH:
                                load_len = bit_val ? 16'(one_high_reg) : 16'(zero_high_reg);
                            PH_BIT_LOW:
                                load_len = bit_val ? 16'(one_low_reg) : 16'(zero_low_reg);
                            default:
                                load_len = {1'b0, latch_reg[15:1]};
                        endcase
                        left = (load_len == 16'd0) ? 16'd1 : load_len;
                    end

                    res_next.line_level = (ph == PH_BIT_HIGH);
                    left = left - 16'd1;

                    // End of a phase: move to the next one.
                    if (left == 16'd0)
                    begin
                        unique case (ph)
                            PH_BIT_HIGH: ph = PH_BIT_LOW;
                            PH_BIT_LOW:
                            begin
                                ph = PH_BIT_HIGH;
                                bit_next = bit_reg + 3'd1;
                                if (bit_reg == 3'd7)
                                begin
                                    if (color_reg == COLOR_BLUE)
                                    begin
                                        color_next = COLOR_RED;
                                        pix_next   = pix_reg + CNT_W'(1);
                                    end
                                    else
                                    begin
                                        color_next = color_reg + 2'd1;
                                    end
                                end
                            end
                            PH_LATCH_FIRST: ph = PH_LATCH_SECOND;
                            default:
                            begin
                                ph = PH_BIT_HIGH;
                                sending_next = 1'b0;
                                pix_next     = '0;
                                color_next   = COLOR_RED;
                                bit_next     = 3'd0;
                                cur          = 8'd0;
                                res_next.frame_done = 1'b1;
                            end
                        endcase
                    end
                    phase_next    = ph;
                    cur_byte_next = cur;
                    left_next     = left;
                end
            end
            CMD_SHOW:
            begin
                if (!sending_reg)
                begin
                    sending_next  = 1'b1;
                    pix_next      = '0;
                    color_next    = COLOR_RED;
                    bit_next      = 3'd0;
                    cur_byte_next = 8'd0;
                    phase_next    = PH_BIT_HIGH;
                    left_next     = 16'd0;
                    res_next.show_accepted = 1'b1;
                end
            end
            default: ;
        endcase

        res_next.busy_res = sending_next;
    end

    // Waveform state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sending_reg  <= 1'b0;
            pix_reg      <= '0;
            color_reg    <= COLOR_RED;
            bit_reg      <= 3'd0;
            cur_byte_reg <= 8'd0;
            phase_reg    <= PH_BIT_HIGH;
            left_reg     <= 16'd0;
        end
        else if (exec_fire)
        begin
            sending_reg  <= sending_next;
            pix_reg      <= pix_next;
            color_reg    <= color_next;
            bit_reg      <= bit_next;
            cur_byte_reg <= cur_byte_next;
            phase_reg    <= phase_next;
            left_reg     <= left_next;
        end
    end

    // Result output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (exec_fire)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec_fire)
        begin
            res_item_reg <= res_next;
        end
    end

endmodule

/* sv/ws2812_checker.sv */
// ----------------------------------------------------------------------------
// ws2812_checker: port level checks of the LED strip driver
// Watches the command and result channels and the result fields over time.
// ----------------------------------------------------------------------------
module ws2812_checker
    import ws2812_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  cmd_valid,
    input logic                  cmd_stall,
    input logic                  res_valid,
    input logic                  res_stall,
    input res_item_t             res_item
);

    // A stalled result stays and holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_item))
        else $error("stalled result changed");

    // After a command transfer the block is busy executing it.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall |=> cmd_stall)
        else $error("command taken during execute");

    // The frame end tick reports the block as no longer busy, with no show or high level.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_item.frame_done |-> !res_item.busy_res
            && !res_item.show_accepted && !res_item.line_level)
        else $error("frame end with busy or other flags");

    // An accepted show or a high line level only happens within a frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_item.show_accepted || res_item.line_level)
            |-> res_item.busy_res)
        else $error("frame activity without busy");

endmodule

bind ws2812_strip_driver_unit ws2812_checker u_ws2812_checker (.*);

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of the WS2812 LED strip driver
// Drives command transfers in random bursts against a receiver that stalls on
// its own pattern, predicts the line level, busy, show and frame-done flags of
// every command, and compares each result transfer with the oldest prediction.
// Several register settings are visited, from the smallest timings up to the
// widest values, and one long receiver hold-off fills the block up.
// ----------------------------------------------------------------------------
module tb_top
    import ws2812_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_BYTES = MAX_PIXELS * BYTES_PER_PIXEL;

    // Scoreboard: own copy of the pixel store, the registers and the waveform
    // state, plus the line results still owed by the block.
    class strip_scoreboard;
        bit [7:0]        pixel_bytes [STORE_BYTES];
        bit [8:0]        pixel_count;
        bit [14:0]       zero_high;
        bit [14:0]       zero_low;
        bit [14:0]       one_high;
        bit [14:0]       one_low;
        bit [15:0]       latch_len;
        bit              sending;
        bit [9:0]        byte_pos;
        bit [2:0]        bit_pos;
        bit [7:0]        cur_byte;
        phase_t          wave_phase;
        bit [15:0]       ticks_left;
        res_item_t       pending_line_states [$];
        int              errors;

        function new();
            foreach (pixel_bytes[i]) pixel_bytes[i] = 8'h00;
            pixel_count = 9'd0;
            zero_high   = 15'd4;
            zero_low    = 15'd8;
            one_high    = 15'd8;
            one_low     = 15'd4;
            latch_len   = 16'd1000;
            errors      = 0;
            stop_frame();
        endfunction

        function void stop_frame();
            sending    = 1'b0;
            byte_pos   = '0;
            bit_pos    = '0;
            cur_byte   = '0;
            wave_phase = PH_BIT_HIGH;
            ticks_left = '0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_PIXEL_COUNT:     pixel_count = value[8:0];
                CFG_ZERO_HIGH_TICKS: zero_high   = value[14:0];
                CFG_ZERO_LOW_TICKS:  zero_low    = value[14:0];
                CFG_ONE_HIGH_TICKS:  one_high    = value[14:0];
                CFG_ONE_LOW_TICKS:   one_low     = value[14:0];
                CFG_LATCH_TICKS:     latch_len   = value;
                default: ;
            endcase
        endfunction

        function bit [15:0] at_least_one(bit [15:0] v);
            return (v == 16'd0) ? 16'd1 : v;
        endfunction

        // The count saturates at the store size and is read at each fetch.
        function int unsigned frame_bytes();
            int unsigned n;
            n = (pixel_count > MAX_PIXELS) ? MAX_PIXELS : pixel_count;
            return n * BYTES_PER_PIXEL;
        endfunction

        // One tick of the line waveform; returns the level during the tick.
        function bit advance_line(output bit done);
            bit level;
            bit data_bit;
            done = 1'b0;
            if (ticks_left == 16'd0)
            begin
                if (wave_phase == PH_BIT_HIGH && bit_pos == 3'd0)
                begin
                    if (byte_pos >= frame_bytes())
                        wave_phase = PH_LATCH_FIRST;
                    else
                        cur_byte = pixel_bytes[byte_pos];
                end
                data_bit = cur_byte[7 - int'(bit_pos)];
                case (wave_phase)
                    PH_BIT_HIGH:
                        ticks_left = at_least_one(data_bit ? 16'(one_high) : 16'(zero_high));
                    PH_BIT_LOW:
                        ticks_left = at_least_one(data_bit ? 16'(one_low) : 16'(zero_low));
                    default:
                        ticks_left = at_least_one(latch_len >> 1);
                endcase
            end
            level = (wave_phase == PH_BIT_HIGH);
            ticks_left--;
            if (ticks_left == 16'd0)
            begin
                case (wave_phase)
                    PH_BIT_HIGH: wave_phase = PH_BIT_LOW;
                    PH_BIT_LOW:
                    begin
                        wave_phase = PH_BIT_HIGH;
                        bit_pos++;
                        if (bit_pos == 3'd0)
                            byte_pos++;
                    end
                    PH_LATCH_FIRST: wave_phase = PH_LATCH_SECOND;
                    default:
                    begin
                        stop_frame();
                        done = 1'b1;
                    end
                endcase
            end
            return level;
        endfunction

        // Works out the result of one accepted command and queues it.
        function void note_command(cmd_item_t c);
            res_item_t   r;
            bit          done;
            int unsigned base;
            r = '0;
            done = 1'b0;
            case (c.cmd)
                CMD_TICK:
                begin
                    if (sending)
                        r.line_level = advance_line(done);
                end
                CMD_SET:
                begin
                    if (c.pixel_index < pixel_count && c.pixel_index < MAX_PIXELS)
                    begin
                        base = c.pixel_index * BYTES_PER_PIXEL;
                        pixel_bytes[base + COLOR_RED]   = c.red;
                        pixel_bytes[base + COLOR_GREEN] = c.green;
                        pixel_bytes[base + COLOR_BLUE]  = c.blue;
                    end
                end
                CMD_CLEAR:
                begin
                    foreach (pixel_bytes[i]) pixel_bytes[i] = 8'h00;
                end
                default:
                begin
                    if (!sending)
                    begin
                        stop_frame();
                        sending = 1'b1;
                        r.show_accepted = 1'b1;
                    end
                end
            endcase
            r.busy_res   = sending;
            r.frame_done = done;
            pending_line_states.push_back(r);
        endfunction

        function void compare_field(string name, logic want, logic got);
            if (got !== want)
            begin
                $display("%0t: %s mismatch, expected %b, actual %b", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(res_item_t r);
            res_item_t want;
            if (pending_line_states.size() == 0)
            begin
                $display("%0t: unexpected result transfer, actual %b", $time, r);
                errors++;
                return;
            end
            want = pending_line_states.pop_front();
            compare_field("line_level", want.line_level, r.line_level);
            compare_field("busy_res", want.busy_res, r.busy_res);
            compare_field("show_accepted", want.show_accepted, r.show_accepted);
            compare_field("frame_done", want.frame_done, r.frame_done);
        endfunction

        function int pending();
            return pending_line_states.size();
        endfunction
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  cmd_valid = 1'b0;
    logic                  cmd_stall;
    cmd_item_t             cmd_item  = '0;
    logic                  res_valid;
    logic                  res_stall = 1'b0;
    res_item_t             res_item;

    strip_scoreboard board = new();
    bit              hold_request = 1'b0;

    ws2812_strip_driver_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_item  (cmd_item),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item)
    );

    // Clock of 10 ns period.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result receiver: stall rate changes in random stretches; on request it
    // holds off for a long stretch so the block backs up.
    initial
    begin : result_receiver
        int unsigned stall_pct;
        int unsigned pattern_left;
        int unsigned hold_left;
        stall_pct    = 0;
        pattern_left = 0;
        hold_left    = 0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                res_stall <= 1'b1;
                hold_left--;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = 300;
                res_stall <= 1'b1;
            end
            else
            begin
                if (pattern_left == 0)
                begin
                    case ($urandom_range(4))
                        0, 1:    stall_pct = 0;
                        2:       stall_pct = 25;
                        3:       stall_pct = 50;
                        default: stall_pct = 85;
                    endcase
                    pattern_left = $urandom_range(10, 80);
                end
                pattern_left--;
                res_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    // Every result transfer is checked at the clock edge that takes it.
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
            board.check_result(res_item);
    end

    // Offers one command from a falling edge and returns at the falling edge
    // after its transfer.
    task automatic push_cmd(cmd_item_t item);
        cmd_valid <= 1'b1;
        cmd_item  <= item;
        do
            @(posedge clk);
        while (cmd_stall);
        board.note_command(item);
        @(negedge clk);
    endtask

    task automatic push_fields(logic [1:0] cmd, logic [7:0] idx,
                               logic [7:0] r, logic [7:0] g, logic [7:0] b);
        cmd_item_t item;
        item.cmd         = cmd;
        item.pixel_index = idx;
        item.red         = r;
        item.green       = g;
        item.blue        = b;
        push_cmd(item);
    endtask

    task automatic push_ticks(int n);
        repeat (n) push_fields(CMD_TICK, 8'h00, 8'h00, 8'h00, 8'h00);
    endtask

    // Waits until the block owes no result.
    task automatic wait_drained();
        cmd_valid <= 1'b0;
        while (board.pending() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        board.write_register(idx, value);
    endtask

    task automatic configure(int unsigned count, int unsigned zh, int unsigned zl,
                             int unsigned oh, int unsigned ol, int unsigned latch);
        wait_drained();
        write_register(CFG_PIXEL_COUNT, CFG_DATA_W'(count));
        write_register(CFG_ZERO_HIGH_TICKS, CFG_DATA_W'(zh));
        write_register(CFG_ZERO_LOW_TICKS, CFG_DATA_W'(zl));
        write_register(CFG_ONE_HIGH_TICKS, CFG_DATA_W'(oh));
        write_register(CFG_ONE_LOW_TICKS, CFG_DATA_W'(ol));
        write_register(CFG_LATCH_TICKS, CFG_DATA_W'(latch));
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    // Mostly ticks so frames run through; set pixel leans toward valid indexes.
    function automatic cmd_item_t random_cmd();
        cmd_item_t   c;
        int unsigned pick;
        int unsigned limit;
        c.pixel_index = 8'($urandom_range(255));
        c.red         = 8'($urandom);
        c.green       = 8'($urandom);
        c.blue        = 8'($urandom);
        pick = $urandom_range(99);
        if (pick < 66)
        begin
            c.cmd = CMD_TICK;
        end
        else if (pick < 86)
        begin
            c.cmd = CMD_SET;
            limit = (board.pixel_count > MAX_PIXELS) ? MAX_PIXELS : board.pixel_count;
            if (limit != 0 && $urandom_range(3) != 0)
                c.pixel_index = 8'($urandom_range(limit - 1));
        end
        else if (pick < 95)
        begin
            c.cmd = CMD_SHOW;
        end
        else
        begin
            c.cmd = CMD_CLEAR;
        end
        return c;
    endfunction

    // Random commands in bursts with random gaps between them.
    task automatic run_random(int n, bit with_hold);
        int sent;
        int burst;
        sent = 0;
        while (sent < n)
        begin
            burst = $urandom_range(1, 30);
            while (burst > 0 && sent < n)
            begin
                push_cmd(random_cmd());
                burst--;
                sent++;
                if (with_hold && sent == n / 3)
                    hold_request = 1'b1;
            end
            if ($urandom_range(2) != 0)
            begin
                cmd_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge clk);
            end
        end
    endtask

    // Main sequence.
    initial
    begin
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: idle tick, ignored set, show accepted then rejected.
        push_fields(CMD_TICK, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        push_fields(CMD_SET, 8'h00, 8'hFF, 8'hFF, 8'hFF);
        push_fields(CMD_SHOW, 8'h00, 8'h00, 8'h00, 8'h00);
        push_fields(CMD_SHOW, 8'hFF, 8'h00, 8'h00, 8'h00);

        // Shortest timings with the frame already started; writes while busy.
        configure(2, 1, 1, 1, 1, 2);
        push_fields(CMD_SET, 8'h00, 8'hFF, 8'h00, 8'hAA);
        push_fields(CMD_SET, 8'h01, 8'h00, 8'hFF, 8'h55);
        push_fields(CMD_SET, 8'h02, 8'h12, 8'h34, 8'h56);
        push_fields(CMD_SET, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        push_ticks(12);
        push_fields(CMD_SET, 8'h01, 8'h80, 8'h01, 8'h7F);
        push_fields(CMD_CLEAR, 8'h00, 8'h00, 8'h00, 8'h00);
        push_fields(CMD_SHOW, 8'h00, 8'h00, 8'h00, 8'h00);
        push_ticks(3);
        run_random(150, 1'b0);

        // Zero phase lengths and a latch time below two.
        configure(1, 0, 0, 0, 0, 0);
        run_random(150, 1'b0);

        // No pixels: a frame is the latch phase only.
        configure(0, 3, 1, 2, 2, 1);
        run_random(100, 1'b0);

        // Full strip, with the long receiver hold-off.
        configure(256, 1, 1, 1, 1, 2);
        run_random(150, 1'b1);

        // Shrinking the count cuts the running frame short; odd latch time.
        configure(3, 2, 3, 3, 2, 5);
        run_random(150, 1'b0);

        repeat (2)
        begin
            configure($urandom_range(4), $urandom_range(1, 4), $urandom_range(1, 4),
                      $urandom_range(1, 4), $urandom_range(1, 4), $urandom_range(2, 9));
            run_random(150, 1'b0);
        end

        // Count above the store size saturates.
        configure(300, 2, 1, 1, 2, 3);
        run_random(100, 1'b0);

        // All ones on every register: widest values, high bits masked off.
        configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_random(100, 1'b0);

        wait_drained();
        repeat (20) @(negedge clk);
        if (board.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Run time limit.
    initial
    begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

/* sim.f */
sv/ws2812_pkg.sv
sv/ws2812_strip_driver_unit.sv
sv/ws2812_checker.sv
tb/tb_top.sv
